// File: sv/servo_bus_packet_slave_macros.svh
// Assertion macros for the servo bus packet slave checks.
`ifndef SERVO_BUS_PACKET_SLAVE_MACROS_SVH
`define SERVO_BUS_PACKET_SLAVE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SVBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("servo bus slave check failed");

// Next-cycle implication.
`define SVBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("servo bus slave check failed");

`endif

// File: sv/svbs_pkg.sv
// Shared types and constants of the servo bus packet slave.
package svbs_pkg;

	localparam logic [7:0] OP_PING      = 8'h01;
	localparam logic [7:0] OP_READ      = 8'h02;
	localparam logic [7:0] OP_WRITE     = 8'h03;
	localparam logic [7:0] OP_REG_WRITE = 8'h04;
	localparam logic [7:0] OP_CLEAR     = 8'h06;

	localparam logic [7:0] PC_MAX   = 8'hFF;
	localparam logic [7:0] LEN_PING = 8'd2;
	localparam logic [7:0] LEN_READ = 8'd6;

	localparam logic [7:0] START_BYTE_RST   = 8'd255;
	localparam logic [7:0] BROADCAST_ID_RST = 8'd254;
	localparam logic [7:0] INITIAL_ID_RST   = 8'd1;
	localparam logic [7:0] ID_ADDR_RST      = 8'd3;
	localparam logic [7:0] SPEED_ADDR_RST   = 8'd36;
	localparam logic [7:0] ORIENT_ADDR_RST  = 8'd37;

	localparam int REPLY_MAX = 10;
	localparam int CNT_W     = 4;

	localparam logic [CNT_W-1:0] CNT_NONE = 4'd1;
	localparam logic [CNT_W-1:0] CNT_PING = 4'd6;
	localparam logic [CNT_W-1:0] CNT_READ = 4'd10;

	typedef enum logic [2:0] {
		PH_START0,
		PH_START1,
		PH_ID,
		PH_LEN,
		PH_INSTR,
		PH_PARAM,
		PH_CHECK
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_CLEAR,
		EV_SAVE
	} event_t;

	typedef enum logic [2:0] {
		CFG_START_BYTE,
		CFG_BROADCAST_ID,
		CFG_INITIAL_ID,
		CFG_ID_ADDR,
		CFG_SPEED_ADDR,
		CFG_ORIENT_ADDR
	} cfg_idx_t;

	// One request's worth of results: reply bytes in send order, or a single event.
	typedef struct packed {
		logic [REPLY_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      tx_valid;
		event_t                    ev;
		logic [7:0]                saved_id;
	} desc_t;

endpackage

// File: sv/servo_bus_packet_slave.sv
// Servo bus packet slave: parses received bus bytes and emits replies and events.
// Each accepted byte passes the input register and the result register and gives
// one or more result items: one item for most bytes, six for a ping reply and ten
// for a register read reply, one item per cycle while out_stall is low. A byte that
// gives a single item is taken every cycle while out_stall is low. During a reply
// the input register holds one more byte and in_stall stays high until the reply's
// final item is taken. The output serialiser sends the reply byte by byte.
// There is no clearing pass after reset.
module servo_bus_packet_slave #(
	parameter int KEPT_PARAMS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic [31:0] speed_word,
	input  logic [31:0] orientation_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        tx_valid,
	output logic [1:0]  event_res,
	output logic [7:0]  saved_id,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import svbs_pkg::*;

	logic        valid_s1;
	logic [7:0]  rx_byte_s1;
	logic [31:0] speed_s1, orient_s1;
	logic        free, step, in_acc;
	desc_t       desc;

	assign in_stall = valid_s1 && !free;
	assign in_acc   = in_valid && !in_stall;
	assign step     = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (step)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rx_byte_s1 <= rx_byte;
			speed_s1   <= speed_word;
			orient_s1  <= orientation_word;
		end
	end

	svbs_parser #(
		.KEPT_PARAMS(KEPT_PARAMS)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.step       (step),
		.rx_byte_s1 (rx_byte_s1),
		.speed_s1   (speed_s1),
		.orient_s1  (orient_s1),
		.desc       (desc)
	);

	svbs_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step),
		.desc_in   (desc),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.tx_byte   (tx_byte),
		.tx_valid  (tx_valid),
		.event_res (event_res),
		.saved_id  (saved_id),
		.last      (last),
		.free      (free)
	);

endmodule

// File: sv/svbs_parser.sv
// Packet parser, configuration registers and reply builder.
module svbs_parser #(
	parameter int KEPT_PARAMS = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [2:0]     cfg_index,
	input  logic [7:0]     cfg_data,
	input  logic           step,
	input  logic [7:0]     rx_byte_s1,
	input  logic [31:0]    speed_s1,
	input  logic [31:0]    orient_s1,
	output svbs_pkg::desc_t desc
);
	import svbs_pkg::*;

	localparam int IDX_W = $clog2(KEPT_PARAMS);

	logic [7:0] start_byte_q, broadcast_id_q, id_addr_q, speed_addr_q, orient_addr_q;
	logic [7:0] node_id_q, node_id_d;
	phase_t     phase_q, phase_d;
	logic [7:0] sum_q, sum_d, pkt_id_q, pkt_id_d, len_q, len_d;
	logic [7:0] instr_q, instr_d, pc_q, pc_d;
	logic [7:0] fp_q [KEPT_PARAMS];
	logic       fp_we;
	logic       idle_go;

	logic [7:0]  c, addr, val;
	logic        own, not_bc;
	logic [31:0] word;
	logic [7:0]  ping_sum, read_sum;

	assign c      = rx_byte_s1;
	assign addr   = fp_q[0];
	assign val    = fp_q[1];
	assign own    = (pkt_id_q == node_id_q);
	assign not_bc = (pkt_id_q != broadcast_id_q);
	assign word   = (addr == speed_addr_q) ? speed_s1 : orient_s1;

	assign ping_sum = node_id_q + LEN_PING + OP_PING;
	assign read_sum = node_id_q + LEN_READ + OP_READ + word[31:24] + word[23:16]
		+ word[15:8] + word[7:0];

	always_comb begin
		phase_d   = phase_q;
		sum_d     = sum_q;
		pkt_id_d  = pkt_id_q;
		len_d     = len_q;
		instr_d   = instr_q;
		pc_d      = pc_q;
		node_id_d = node_id_q;
		fp_we     = 1'b0;
		idle_go   = 1'b0;
		desc          = '0;
		desc.count    = CNT_NONE;
		desc.tx_valid = 1'b0;
		desc.ev       = EV_NONE;
		case (phase_q)
			PH_START0, PH_START1: begin
				if (c == start_byte_q)
					phase_d = (phase_q == PH_START0) ? PH_START1 : PH_ID;
				else
					idle_go = 1'b1;
			end
			PH_ID: begin
				sum_d    = c;
				pkt_id_d = c;
				if (c == node_id_q || c == broadcast_id_q)
					phase_d = PH_LEN;
				else
					idle_go = 1'b1;
			end
			PH_LEN: begin
				sum_d   = sum_q + c;
				len_d   = c;
				phase_d = PH_INSTR;
			end
			PH_INSTR: begin
				sum_d   = sum_q + c;
				instr_d = c;
				phase_d = (c == OP_PING) ? PH_CHECK : PH_PARAM;
			end
			PH_PARAM: begin
				sum_d = sum_q + c;
				fp_we = (pc_q < 8'(KEPT_PARAMS));
				pc_d  = (pc_q != PC_MAX) ? pc_q + 8'd1 : pc_q;
				if ({1'b0, pc_d} + 9'd2 >= {1'b0, len_q})
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				idle_go = 1'b1;
				if (c == ~sum_q) begin
					if (instr_q == OP_PING && own) begin
						desc.bytes[0] = start_byte_q;
						desc.bytes[1] = start_byte_q;
						desc.bytes[2] = node_id_q;
						desc.bytes[3] = LEN_PING;
						desc.bytes[4] = OP_PING;
						desc.bytes[5] = ~ping_sum;
						desc.count    = CNT_PING;
						desc.tx_valid = 1'b1;
					end else if (instr_q == OP_READ && own &&
						(addr == speed_addr_q || addr == orient_addr_q)) begin
						desc.bytes[0] = start_byte_q;
						desc.bytes[1] = start_byte_q;
						desc.bytes[2] = node_id_q;
						desc.bytes[3] = LEN_READ;
						desc.bytes[4] = OP_READ;
						desc.bytes[5] = word[31:24];
						desc.bytes[6] = word[23:16];
						desc.bytes[7] = word[15:8];
						desc.bytes[8] = word[7:0];
						desc.bytes[9] = ~read_sum;
						desc.count    = CNT_READ;
						desc.tx_valid = 1'b1;
					end else if (instr_q == OP_CLEAR) begin
						desc.ev = EV_CLEAR;
					end else if (instr_q == OP_WRITE && addr == id_addr_q && not_bc) begin
						node_id_d = val;
					end else if (instr_q == OP_REG_WRITE && addr == id_addr_q && not_bc) begin
						node_id_d     = val;
						desc.ev       = EV_SAVE;
						desc.saved_id = val;
					end
				end
			end
			default: idle_go = 1'b1;
		endcase
		if (idle_go) begin
			phase_d  = PH_START0;
			sum_d    = '0;
			pkt_id_d = '0;
			len_d    = '0;
			instr_d  = '0;
			pc_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= START_BYTE_RST;
			broadcast_id_q <= BROADCAST_ID_RST;
			id_addr_q      <= ID_ADDR_RST;
			speed_addr_q   <= SPEED_ADDR_RST;
			orient_addr_q  <= ORIENT_ADDR_RST;
			node_id_q      <= INITIAL_ID_RST;
			phase_q        <= PH_START0;
			sum_q          <= '0;
			pkt_id_q       <= '0;
			len_q          <= '0;
			instr_q        <= '0;
			pc_q           <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_START_BYTE:   start_byte_q   <= cfg_data;
				CFG_BROADCAST_ID: broadcast_id_q <= cfg_data;
				CFG_INITIAL_ID:   node_id_q      <= cfg_data;
				CFG_ID_ADDR:      id_addr_q      <= cfg_data;
				CFG_SPEED_ADDR:   speed_addr_q   <= cfg_data;
				CFG_ORIENT_ADDR:  orient_addr_q  <= cfg_data;
				default: ;
			endcase
		end else if (step) begin
			node_id_q <= node_id_d;
			phase_q   <= phase_d;
			sum_q     <= sum_d;
			pkt_id_q  <= pkt_id_d;
			len_q     <= len_d;
			instr_q   <= instr_d;
			pc_q      <= pc_d;
		end
	end

	// Kept parameters: no reset; one that the packet did not write keeps its old value.
	always_ff @(posedge clk) begin
		if (step && fp_we)
			fp_q[pc_q[IDX_W-1:0]] <= c;
	end

endmodule

// File: sv/svbs_tx.sv
// Result register and reply serialiser.
module svbs_tx (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  svbs_pkg::desc_t desc_in,
	input  logic            out_stall,
	output logic            out_valid,
	output logic [7:0]      tx_byte,
	output logic            tx_valid,
	output logic [1:0]      event_res,
	output logic [7:0]      saved_id,
	output logic            last,
	output logic            free
);
	import svbs_pkg::*;

	desc_t            desc_s2;
	logic             valid_s2;
	logic [CNT_W-1:0] idx_q;
	logic             accept;

	assign last      = (idx_q == desc_s2.count - 4'd1);
	assign accept    = valid_s2 && !out_stall;
	assign free      = !valid_s2 || (accept && last);
	assign out_valid = valid_s2;
	assign tx_byte   = desc_s2.bytes[idx_q];
	assign tx_valid  = desc_s2.tx_valid;
	assign event_res = desc_s2.ev;
	assign saved_id  = desc_s2.saved_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (accept && last) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (accept) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			desc_s2 <= desc_in;
	end

endmodule

// File: sv/svbs_checker.sv
// Port-level checks of the servo bus packet slave, bound to the top level.
`include "servo_bus_packet_slave_macros.svh"

module svbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] tx_byte,
	input logic       tx_valid,
	input logic [1:0] event_res,
	input logic [7:0] saved_id,
	input logic       last
);
	import svbs_pkg::*;

	// a held request keeps its payload
	`SVBS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(tx_byte) && $stable(last))
	// only reply bytes run on past one item
	`SVBS_ASSERT_IMPL(a_multi_is_reply, clk, arst_n, out_valid && !last, tx_valid)
	// events travel alone
	`SVBS_ASSERT_IMPL(a_event_alone, clk, arst_n, out_valid && event_res != EV_NONE, !tx_valid && last)
	`SVBS_ASSERT_IMPL(a_saved_id_zero, clk, arst_n, out_valid && event_res != EV_SAVE, saved_id == 8'd0)

endmodule

bind servo_bus_packet_slave svbs_checker u_svbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tx_byte   (tx_byte),
	.tx_valid  (tx_valid),
	.event_res (event_res),
	.saved_id  (saved_id),
	.last      (last)
);

// File: verif/tb_servo_bus_packet_slave.sv
// Self-checking testbench for the servo bus packet slave: directed and random bus traffic.
module tb_servo_bus_packet_slave;
	timeunit 1ns;
	timeprecision 1ps;

	import svbs_pkg::*;

	localparam int KEPT        = 2;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE      = 20;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic [7:0] tx;
		logic       txv;
		event_t     ev;
		logic [7:0] sid;
		logic       fin;
	} result_t;

	logic        clk;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte          = '0;
	logic [31:0] speed_word       = '0;
	logic [31:0] orientation_word = '0;
	logic        out_valid;
	logic        out_stall        = 1'b0;
	logic [7:0]  tx_byte;
	logic        tx_valid;
	logic [1:0]  event_res;
	logic [7:0]  saved_id;
	logic        last;
	logic        cfg_wr_en        = 1'b0;
	logic [2:0]  cfg_index        = CFG_START_BYTE;
	logic [7:0]  cfg_data         = '0;

	servo_bus_packet_slave #(.KEPT_PARAMS(KEPT)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.rx_byte(rx_byte), .speed_word(speed_word), .orientation_word(orientation_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.tx_byte(tx_byte), .tx_valid(tx_valid), .event_res(event_res),
		.saved_id(saved_id), .last(last),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register copies
	logic [7:0] r_start, r_bcast, r_init, r_id_addr, r_speed_addr, r_orient_addr;
	// parser copy
	phase_t     ps_phase;
	logic [7:0] ps_sum, ps_id, ps_len, ps_instr, ps_count, ps_node;
	logic [7:0] ps_params [KEPT];

	result_t results_due[$];
	result_t want;

	int gap_pct   = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int errors    = 0;
	int n_bytes   = 0;
	int n_results = 0;
	int n_settings = 0;
	int n_pings = 0, n_reads = 0, n_clears = 0, n_saves = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: tx_byte %0h event %0d", tx_byte, event_res);
				errors++;
			end else begin
				want = results_due.pop_front();
				check_field("tx_byte", want.tx, tx_byte);
				check_field("tx_valid", want.txv, tx_valid);
				check_field("event_res", want.ev, event_res);
				check_field("saved_id", want.sid, saved_id);
				check_field("last", want.fin, last);
				n_results++;
			end
		end
	end

	function automatic void parser_idle();
		ps_phase = PH_START0;
		ps_sum   = '0;
		ps_id    = '0;
		ps_len   = '0;
		ps_instr = '0;
		ps_count = '0;
	endfunction

	function automatic void queue_reply(logic [7:0] op, int n, logic [31:0] w);
		byte_q_t    seq;
		logic [7:0] len, sum, d;
		result_t    r;
		len = (n == 0) ? LEN_PING : LEN_READ;
		sum = ps_node + len + op;
		seq = '{r_start, r_start, ps_node, len, op};
		for (int i = 0; i < n; i++) begin
			d = w[31 - 8 * i -: 8];
			seq.push_back(d);
			sum = sum + d;
		end
		seq.push_back(~sum);
		foreach (seq[i]) begin
			r.tx  = seq[i];
			r.txv = 1'b1;
			r.ev  = EV_NONE;
			r.sid = '0;
			r.fin = (i == seq.size() - 1);
			results_due.push_back(r);
		end
	endfunction

	task automatic parse_rx_byte(input logic [7:0] c, input logic [31:0] spd,
			input logic [31:0] ori);
		event_t     ev;
		logic [7:0] sid, addr, val, inv;
		logic       own, not_bc;
		result_t    r;
		ev  = EV_NONE;
		sid = '0;
		case (ps_phase)
			PH_START0, PH_START1: begin
				if (c == r_start)
					ps_phase = (ps_phase == PH_START0) ? PH_START1 : PH_ID;
				else
					parser_idle();
			end
			PH_ID: begin
				ps_sum = c;
				ps_id  = c;
				if (c == ps_node || c == r_bcast)
					ps_phase = PH_LEN;
				else
					parser_idle();
			end
			PH_LEN: begin
				ps_sum   = ps_sum + c;
				ps_len   = c;
				ps_phase = PH_INSTR;
			end
			PH_INSTR: begin
				ps_sum   = ps_sum + c;
				ps_instr = c;
				ps_phase = (c == OP_PING) ? PH_CHECK : PH_PARAM;
			end
			PH_PARAM: begin
				ps_sum = ps_sum + c;
				if (ps_count < KEPT)
					ps_params[ps_count] = c;
				if (ps_count != PC_MAX)
					ps_count++;
				if (int'(ps_count) + 2 >= int'(ps_len))
					ps_phase = PH_CHECK;
			end
			PH_CHECK: begin
				inv = ~ps_sum;
				if (c == inv) begin
					addr   = ps_params[0];
					val    = ps_params[1];
					own    = (ps_id == ps_node);
					not_bc = (ps_id != r_bcast);
					if (ps_instr == OP_PING && own) begin
						queue_reply(OP_PING, 0, '0);
						n_pings++;
						parser_idle();
						return;
					end
					if (ps_instr == OP_READ && own &&
							(addr == r_speed_addr || addr == r_orient_addr)) begin
						queue_reply(OP_READ, 4, (addr == r_speed_addr) ? spd : ori);
						n_reads++;
						parser_idle();
						return;
					end
					if (ps_instr == OP_CLEAR)
						ev = EV_CLEAR;
					if (ps_instr == OP_WRITE && addr == r_id_addr && not_bc)
						ps_node = val;
					if (ps_instr == OP_REG_WRITE && addr == r_id_addr && not_bc) begin
						ps_node = val;
						ev      = EV_SAVE;
						sid     = val;
					end
				end
				parser_idle();
			end
			default: parser_idle();
		endcase
		if (ev == EV_CLEAR)
			n_clears++;
		if (ev == EV_SAVE)
			n_saves++;
		r.tx  = '0;
		r.txv = 1'b0;
		r.ev  = ev;
		r.sid = sid;
		r.fin = 1'b1;
		results_due.push_back(r);
	endtask

	function automatic void store_reg(cfg_idx_t idx, logic [7:0] v);
		case (idx)
			CFG_START_BYTE:   r_start = v;
			CFG_BROADCAST_ID: r_bcast = v;
			CFG_INITIAL_ID: begin
				r_init  = v;
				ps_node = v;
			end
			CFG_ID_ADDR:      r_id_addr = v;
			CFG_SPEED_ADDR:   r_speed_addr = v;
			CFG_ORIENT_ADDR:  r_orient_addr = v;
			default: ;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [31:0] spd,
			input logic [31:0] ori);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		rx_byte          <= b;
		speed_word       <= spd;
		orientation_word <= ori;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		parse_rx_byte(b, spd, ori);
		n_bytes++;
	endtask

	task automatic send_request(input byte_q_t q, input logic [31:0] spd,
			input logic [31:0] ori);
		foreach (q[i])
			send_byte(q[i], spd, ori);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [7:0] sb, bc, ini, ida, spa, ora);
		logic [7:0] vals [6];
		cfg_idx_t   idx;
		vals = '{sb, bc, ini, ida, spa, ora};
		wait_for_results();
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[int'(idx)];
			@(posedge clk);
			store_reg(idx, vals[int'(idx)]);
			idx = idx.next();
		end
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	function automatic byte_q_t build_frame(logic [7:0] id, len, instr, p0, p1, bit good);
		byte_q_t    q;
		int         n;
		logic [7:0] sum, b, cs;
		q   = '{r_start, r_start, id, len, instr};
		sum = id + len + instr;
		n   = (instr == OP_PING) ? 0 : ((len <= 8'd3) ? 1 : int'(len) - 2);
		for (int i = 0; i < n; i++) begin
			b = (i == 0) ? p0 : (i == 1) ? p1 : 8'($urandom);
			q.push_back(b);
			sum = sum + b;
		end
		cs = ~sum;
		if (!good)
			cs = cs ^ (8'd1 << $urandom_range(0, 7));
		q.push_back(cs);
		return q;
	endfunction

	function automatic byte_q_t random_request();
		byte_q_t    q;
		int         kind, sel, n;
		logic [7:0] id, len, instr, p0, p1;
		kind = $urandom_range(0, 99);
		if (kind >= 88) begin
			n = $urandom_range(1, 4);
			repeat (n) q.push_back(8'($urandom));
			return q;
		end
		sel = $urandom_range(0, 9);
		id  = (sel < 6) ? ps_node : (sel < 8) ? r_bcast : 8'($urandom);
		case ($urandom_range(0, 6))
			0:       instr = OP_PING;
			1, 2:    instr = OP_READ;
			3:       instr = OP_WRITE;
			4:       instr = OP_REG_WRITE;
			5:       instr = OP_CLEAR;
			default: instr = 8'($urandom);
		endcase
		sel = $urandom_range(0, 3);
		p0  = (sel == 0) ? r_speed_addr : (sel == 1) ? r_orient_addr :
			(sel == 2) ? r_id_addr : 8'($urandom);
		p1  = 8'($urandom);
		if ($urandom_range(0, 3) == 0)
			len = 8'($urandom_range(0, 8));
		else
			len = (instr == OP_PING) ? LEN_PING : 8'($urandom_range(3, 5));
		q = build_frame(id, len, instr, p0, p1, $urandom_range(0, 9) != 0);
		if (kind >= 76) begin
			if ($urandom_range(0, 1) == 1) begin
				n = $urandom_range(1, q.size() - 1);
				repeat (n) void'(q.pop_back());
			end else begin
				q[$urandom_range(0, 1)] = r_start ^ 8'($urandom_range(1, 255));
			end
		end
		return q;
	endfunction

	task automatic run_traffic(input int count);
		int first;
		first = n_bytes;
		while (n_bytes - first < count)
			send_request(random_request(), $urandom, $urandom);
	endtask

	// reset register values, every instruction and the parser's corner cases
	task automatic test_instructions();
		send_request(build_frame(ps_node, 8'd4, OP_WRITE, 8'h10, 8'h55, 1), $urandom, $urandom);
		send_request(build_frame(ps_node, LEN_PING, OP_PING, 0, 0, 1), $urandom, $urandom);
		send_request(build_frame(r_bcast, LEN_PING, OP_PING, 0, 0, 1), $urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_READ, r_speed_addr, 8'd4, 1),
			32'hFFFF_FFFF, 32'h0);
		send_request(build_frame(ps_node, 8'd4, OP_READ, 8'h00, 8'd4, 1), $urandom, $urandom);
		send_request(build_frame(r_bcast, 8'd0, OP_CLEAR, 8'hFF, 0, 1), $urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_WRITE, r_id_addr, 8'h20, 1),
			$urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_REG_WRITE, r_id_addr, 8'h00, 1),
			$urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, 8'h7F, 8'h10, 8'h11, 1), $urandom, $urandom);
		send_request(build_frame(ps_node, LEN_PING, OP_PING, 0, 0, 0), $urandom, $urandom);
		send_request(build_frame(ps_node, 8'd8, OP_WRITE, 8'h10, 8'h11, 1), $urandom, $urandom);
	endtask

	// extreme register values, then equal read addresses
	task automatic test_register_settings();
		configure(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
		send_request(build_frame(ps_node, LEN_PING, OP_PING, 0, 0, 1), $urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_READ, r_speed_addr, 8'd4, 1),
			$urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_WRITE, r_id_addr, 8'hFE, 1),
			$urandom, $urandom);
		configure(8'hAA, 8'h00, 8'hFF, 8'hFF, 8'h55, 8'h55);
		send_request(build_frame(ps_node, 8'd4, OP_READ, 8'h55, 8'd4, 1), $urandom, $urandom);
		send_request(build_frame(r_bcast, 8'd4, OP_WRITE, r_id_addr, 8'h12, 1),
			$urandom, $urandom);
		send_request(build_frame(r_bcast, LEN_PING, OP_CLEAR, 8'h01, 0, 1), $urandom, $urandom);
	endtask

	task automatic test_random_traffic(input int count);
		configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
		run_traffic(count);
	endtask

	// receiver holds off while replies queue up, then the sender waits for all results
	task automatic test_backpressure();
		configure(START_BYTE_RST, BROADCAST_ID_RST, INITIAL_ID_RST, ID_ADDR_RST,
			SPEED_ADDR_RST, ORIENT_ADDR_RST);
		hold_reqs <= hold_reqs + 1;
		send_request(build_frame(ps_node, LEN_PING, OP_PING, 0, 0, 1), $urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_READ, r_speed_addr, 8'd4, 1),
			$urandom, $urandom);
		send_request(build_frame(ps_node, 8'd4, OP_READ, r_orient_addr, 8'd4, 1),
			$urandom, $urandom);
		wait_for_results();
		send_request(build_frame(ps_node, LEN_PING, OP_PING, 0, 0, 1), $urandom, $urandom);
		wait_for_results();
	endtask

	initial begin
		r_start       = START_BYTE_RST;
		r_bcast       = BROADCAST_ID_RST;
		r_init        = INITIAL_ID_RST;
		r_id_addr     = ID_ADDR_RST;
		r_speed_addr  = SPEED_ADDR_RST;
		r_orient_addr = ORIENT_ADDR_RST;
		ps_node       = INITIAL_ID_RST;
		ps_params     = '{default: '0};
		parser_idle();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 36;
		stall_pct = 84;
		test_instructions();
		test_random_traffic(6);
		gap_pct   = 84;
		stall_pct = 36;
		test_register_settings();
		test_random_traffic(6);
		gap_pct   = 0;
		stall_pct = 0;
		test_random_traffic(6);
		test_backpressure();

		repeat (SETTLE) @(posedge clk);
		if (results_due.size() != 0) begin
			$error("%0d expected results never arrived", results_due.size());
			errors++;
		end
		$display("Sent %0d bus bytes under %0d register settings, checked %0d result items.",
			n_bytes, n_settings, n_results);
		$display("Replies: %0d ping, %0d read; events: %0d clear, %0d save.",
			n_pings, n_reads, n_clears, n_saves);
		if (errors == 0)
			$display("tb_servo_bus_packet_slave passed");
		else
			$display("tb_servo_bus_packet_slave failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_servo_bus_packet_slave failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/svbs_pkg.sv
sv/svbs_parser.sv
sv/svbs_tx.sv
sv/servo_bus_packet_slave.sv
sv/svbs_checker.sv
verif/tb_servo_bus_packet_slave.sv
